// File: rtl/dmf_pkg.sv
// types, codes and states shared by the max-flow engine
`default_nettype none

package dmf_pkg;

    localparam logic [2:0] MODE_CLEAR = 3'd0;
    localparam logic [2:0] MODE_ADD   = 3'd1;
    localparam logic [2:0] MODE_RUN   = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_CUT   = 3'd4;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_MISSING = 2'd2;

    localparam logic [1:0] CFG_SOURCE = 2'd0;
    localparam logic [1:0] CFG_SINK   = 2'd1;
    localparam logic [1:0] CFG_LIMIT  = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  from_vertex;
        logic [5:0]  to_vertex;
        logic [31:0] capacity;
        logic [7:0]  edge_index;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  source_vertex;
        logic [5:0]  sink_vertex;
        logic [31:0] flow_cap;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  edge_id;
        logic [31:0] total_flow;
        logic [5:0]  edge_tail;
        logic [5:0]  edge_head;
        logic [31:0] edge_capacity;
        logic [31:0] edge_flow;
        logic        on_source_side;
    } t_res;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DONE,
        ST_AP_RD,
        ST_AP_WR,
        ST_AP_LINK,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_SW_INIT,
        ST_SW_POP,
        ST_SW_V,
        ST_SW_F,
        ST_SW_ARC,
        ST_SW_CHK,
        ST_RUN_LOOP,
        ST_RUN_PHASE,
        ST_P_START,
        ST_P_FRAME,
        ST_P_CUR,
        ST_P_SCAN,
        ST_P_A,
        ST_P_L,
        ST_P_RET,
        ST_P_POP1,
        ST_P_POP2,
        ST_P_U1,
        ST_P_U2,
        ST_P_ADV,
        ST_P_END
    } t_state;

endpackage

`default_nettype wire

// File: rtl/dinic_max_flow_engine.sv
// top level: stream ports, configuration registers and result register
`default_nettype none

// Graph store with a Dinic max-flow sequencer. One command is worked at a
// time; all tables sit in single-port-read rams, so each step reads each
// ram at most once. A cut query is a bfs from the source over arcs with
// residual capacity. A run repeats one bfs leveling plus dfs pushes,
// until the sink is cut off or the limit is met. Vertex tables are
// cleared by valid bits, with no clearing pass. The next command is taken
// while the previous result waits at the output.
module dinic_max_flow_engine
    import dmf_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int CAP_WIDTH    = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // from_vertex[5:0], to_vertex[11:6], capacity[43:12], edge_index[51:44]
    input  wire logic [55:0]  i_s_tdata,
    // mode[2:0]
    input  wire logic [2:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // edge_id[7:0], total_flow[39:8], edge_tail[45:40], edge_head[51:46],
    // edge_capacity[83:52], edge_flow[115:84], on_source_side[116]
    output logic      [119:0] o_m_tdata,
    // status[1:0]
    output logic      [1:0]   o_m_tuser,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    t_cfg r_cfg;
    t_cmd cmd;
    t_res core_res, r_out;
    logic r_out_valid;
    logic core_valid;
    logic core_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_vertex <= 6'd0;
            r_cfg.sink_vertex   <= 6'd1;
            r_cfg.flow_cap      <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SOURCE: r_cfg.source_vertex <= i_cfg_data[5:0];
                CFG_SINK:   r_cfg.sink_vertex   <= i_cfg_data[5:0];
                CFG_LIMIT:  r_cfg.flow_cap      <= i_cfg_data;
                default:    r_cfg.flow_cap      <= r_cfg.flow_cap;
            endcase
        end
    end

    assign cmd.mode        = i_s_tuser;
    assign cmd.from_vertex = i_s_tdata[5:0];
    assign cmd.to_vertex   = i_s_tdata[11:6];
    assign cmd.capacity    = i_s_tdata[43:12];
    assign cmd.edge_index  = i_s_tdata[51:44];

    assign core_ready = !r_out_valid || i_m_tready;

    dmf_core #(
        .MAX_VERTICES(MAX_VERTICES),
        .MAX_EDGES(MAX_EDGES),
        .CAP_WIDTH(CAP_WIDTH)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd_valid(i_s_tvalid),
        .o_cmd_ready(o_s_tready),
        .i_cmd(cmd),
        .i_cfg(r_cfg),
        .o_res_valid(core_valid),
        .i_res_ready(core_ready),
        .o_res(core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_valid && core_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (core_valid && core_ready) begin
            r_out <= core_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {3'b000, r_out.on_source_side, r_out.edge_flow,
                         r_out.edge_capacity, r_out.edge_head, r_out.edge_tail,
                         r_out.total_flow, r_out.edge_id};

endmodule

`default_nettype wire

// File: rtl/dmf_ram.sv
// generic single-write, single-read synchronous ram with registered read
`default_nettype none

module dmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/dmf_core.sv
// graph store, bfs leveling and dfs push sequencer over the table rams
`default_nettype none

module dmf_core
    import dmf_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 256,
    parameter int CAP_WIDTH    = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    input  wire t_cfg i_cfg,
    output logic      o_res_valid,
    input  wire logic i_res_ready,
    output t_res      o_res
);

    localparam int NV    = MAX_VERTICES;
    localparam int VW    = $clog2(NV);
    localparam int QW    = $clog2(NV + 1);
    localparam int NARCS = 2 * MAX_EDGES;
    localparam int ARW   = $clog2(NARCS);
    localparam int AW    = $clog2(NARCS + 1);
    localparam int CNW   = $clog2(MAX_EDGES + 1);
    localparam int CW    = CAP_WIDTH;
    localparam int SW    = VW + 2 * CW;
    localparam logic [AW-1:0] NOARC = AW'(NARCS);

    function automatic logic [VW-1:0] vmod(input logic [5:0] x);
        logic [VW-1:0] y;
        y = '0;
        for (int k = 0; k < 64; k++) begin
            if (x == 6'(k)) begin
                y = VW'(k % MAX_VERTICES);
            end
        end
        return y;
    endfunction

    t_state r_state, n_state;
    logic [CNW-1:0] r_cnt, n_cnt;
    logic [NV-1:0]  r_vok, n_vok, r_cok, n_cok, r_seen, n_seen;
    logic           r_lev, n_lev, r_run, n_run, r_pass, n_pass;
    logic [QW-1:0]  r_qh, n_qh, r_qt, n_qt;
    logic [VW-1:0]  r_v, n_v, r_lv, n_lv, r_h, n_h, r_fv, n_fv, r_top, n_top;
    logic [VW-1:0]  r_s, n_s, r_t, n_t, r_qv, n_qv, r_owner, n_owner, r_hv, n_hv;
    logic [AW-1:0]  r_a, n_a, r_nx, n_nx, r_link, n_link;
    logic [CW-1:0]  r_r, n_r, r_fup, n_fup, r_fres, n_fres, r_ret, n_ret;
    logic [CW-1:0]  r_total, n_total, r_lim, n_lim, r_resv, n_resv;
    t_res           r_res, n_res;

    logic           head_we, res_we, next_we, first_we, last_we;
    logic           level_we, cur_we, queue_we, stack_we;
    logic [ARW-1:0] head_wa, head_ra, res_wa, res_ra, next_wa, next_ra;
    logic [VW-1:0]  first_wa, first_ra, last_wa, last_ra, level_wa, level_ra;
    logic [VW-1:0]  cur_wa, cur_ra, queue_wa, queue_ra, stack_wa, stack_ra;
    logic [VW-1:0]  head_wd, head_rd, level_wd, level_rd, queue_wd, queue_rd;
    logic [CW-1:0]  res_wd, res_rd;
    logic [AW-1:0]  next_wd, next_rd, first_wd, first_rd, last_wd, last_rd;
    logic [AW-1:0]  cur_wd, cur_rd;
    logic [SW-1:0]  stack_wd, stack_rd;

    dmf_ram #(.WIDTH(VW), .DEPTH(NARCS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_wa), .i_wdata(head_wd),
        .i_raddr(head_ra), .o_rdata(head_rd));
    dmf_ram #(.WIDTH(CW), .DEPTH(NARCS)) u_res (
        .i_clk(i_clk), .i_we(res_we), .i_waddr(res_wa), .i_wdata(res_wd),
        .i_raddr(res_ra), .o_rdata(res_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NARCS)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_wa), .i_wdata(next_wd),
        .i_raddr(next_ra), .o_rdata(next_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NV)) u_first (
        .i_clk(i_clk), .i_we(first_we), .i_waddr(first_wa), .i_wdata(first_wd),
        .i_raddr(first_ra), .o_rdata(first_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NV)) u_last (
        .i_clk(i_clk), .i_we(last_we), .i_waddr(last_wa), .i_wdata(last_wd),
        .i_raddr(last_ra), .o_rdata(last_rd));
    dmf_ram #(.WIDTH(VW), .DEPTH(NV)) u_level (
        .i_clk(i_clk), .i_we(level_we), .i_waddr(level_wa), .i_wdata(level_wd),
        .i_raddr(level_ra), .o_rdata(level_rd));
    dmf_ram #(.WIDTH(AW), .DEPTH(NV)) u_cur (
        .i_clk(i_clk), .i_we(cur_we), .i_waddr(cur_wa), .i_wdata(cur_wd),
        .i_raddr(cur_ra), .o_rdata(cur_rd));
    dmf_ram #(.WIDTH(VW), .DEPTH(NV)) u_queue (
        .i_clk(i_clk), .i_we(queue_we), .i_waddr(queue_wa), .i_wdata(queue_wd),
        .i_raddr(queue_ra), .o_rdata(queue_rd));
    dmf_ram #(.WIDTH(SW), .DEPTH(NV)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(stack_wa), .i_wdata(stack_wd),
        .i_raddr(stack_ra), .o_rdata(stack_rd));

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res       = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_vok   <= '0;
            r_cok   <= '0;
            r_seen  <= '0;
            r_qh    <= '0;
            r_qt    <= '0;
            r_top   <= '0;
            r_total <= '0;
            r_lim   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_vok   <= n_vok;
            r_cok   <= n_cok;
            r_seen  <= n_seen;
            r_qh    <= n_qh;
            r_qt    <= n_qt;
            r_top   <= n_top;
            r_total <= n_total;
            r_lim   <= n_lim;
        end
        r_lev   <= n_lev;
        r_run   <= n_run;
        r_pass  <= n_pass;
        r_v     <= n_v;
        r_lv    <= n_lv;
        r_h     <= n_h;
        r_fv    <= n_fv;
        r_s     <= n_s;
        r_t     <= n_t;
        r_qv    <= n_qv;
        r_owner <= n_owner;
        r_hv    <= n_hv;
        r_a     <= n_a;
        r_nx    <= n_nx;
        r_link  <= n_link;
        r_r     <= n_r;
        r_fup   <= n_fup;
        r_fres  <= n_fres;
        r_ret   <= n_ret;
        r_resv  <= n_resv;
        r_res   <= n_res;
    end

    always_comb begin
        logic [AW-1:0] link;
        logic [CW-1:0] sum;
        logic [CW-1:0] room;
        logic [CW-1:0] fsum;
        logic [CW-1:0] tsum;
        link    = NOARC;
        sum     = r_r + res_rd;
        room    = r_fup - r_fres;
        fsum    = r_fres + r_ret;
        tsum    = r_total + r_ret;
        n_state = r_state;
        n_cnt   = r_cnt;
        n_vok   = r_vok;
        n_cok   = r_cok;
        n_seen  = r_seen;
        n_lev   = r_lev;
        n_run   = r_run;
        n_pass  = r_pass;
        n_qh    = r_qh;
        n_qt    = r_qt;
        n_v     = r_v;
        n_lv    = r_lv;
        n_h     = r_h;
        n_fv    = r_fv;
        n_top   = r_top;
        n_s     = r_s;
        n_t     = r_t;
        n_qv    = r_qv;
        n_owner = r_owner;
        n_hv    = r_hv;
        n_a     = r_a;
        n_nx    = r_nx;
        n_link  = r_link;
        n_r     = r_r;
        n_fup   = r_fup;
        n_fres  = r_fres;
        n_ret   = r_ret;
        n_total = r_total;
        n_lim   = r_lim;
        n_resv  = r_resv;
        n_res   = r_res;
        head_we = 1'b0; head_wa = '0; head_wd = '0; head_ra = '0;
        res_we  = 1'b0; res_wa  = '0; res_wd  = '0; res_ra  = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0; next_ra = '0;
        first_we = 1'b0; first_wa = '0; first_wd = '0; first_ra = '0;
        last_we = 1'b0; last_wa = '0; last_wd = '0; last_ra = '0;
        level_we = 1'b0; level_wa = '0; level_wd = '0; level_ra = '0;
        cur_we  = 1'b0; cur_wa  = '0; cur_wd  = '0; cur_ra  = '0;
        queue_we = 1'b0; queue_wa = '0; queue_wd = '0; queue_ra = '0;
        stack_we = 1'b0; stack_wa = '0; stack_wd = '0; stack_ra = '0;

        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_res   = '0;
                    n_state = ST_DONE;
                    case (i_cmd.mode)
                        MODE_CLEAR: begin
                            n_vok  = '0;
                            n_seen = '0;
                            n_cnt  = '0;
                        end
                        MODE_ADD: begin
                            if (r_cnt == CNW'(MAX_EDGES)) begin
                                n_res.status = STAT_FULL;
                            end else begin
                                n_owner = vmod(i_cmd.from_vertex);
                                n_hv    = vmod(i_cmd.to_vertex);
                                n_a     = AW'({r_cnt, 1'b0});
                                n_resv  = CW'(i_cmd.capacity);
                                n_pass  = 1'b0;
                                n_state = ST_AP_RD;
                            end
                        end
                        MODE_RUN: begin
                            n_s     = vmod(i_cfg.source_vertex);
                            n_t     = vmod(i_cfg.sink_vertex);
                            n_lim   = CW'(i_cfg.flow_cap);
                            n_total = '0;
                            n_run   = 1'b1;
                            n_state = ST_RUN_LOOP;
                        end
                        MODE_READ: begin
                            if (32'(i_cmd.edge_index) >= 32'(r_cnt)) begin
                                n_res.status = STAT_MISSING;
                            end else begin
                                n_a     = AW'({i_cmd.edge_index, 1'b0});
                                n_state = ST_RD0;
                            end
                        end
                        MODE_CUT: begin
                            n_s     = vmod(i_cfg.source_vertex);
                            n_qv    = vmod(i_cmd.from_vertex);
                            n_run   = 1'b0;
                            n_lev   = 1'b0;
                            n_state = ST_SW_INIT;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            ST_AP_RD: begin
                last_ra = r_owner;
                n_state = ST_AP_WR;
            end
            ST_AP_WR: begin
                link     = r_vok[r_owner] ? last_rd : NOARC;
                n_link   = link;
                head_we  = 1'b1;
                head_wa  = r_a[ARW-1:0];
                head_wd  = r_hv;
                res_we   = 1'b1;
                res_wa   = r_a[ARW-1:0];
                res_wd   = r_resv;
                next_we  = 1'b1;
                next_wa  = r_a[ARW-1:0];
                next_wd  = NOARC;
                last_we  = 1'b1;
                last_wa  = r_owner;
                last_wd  = r_a;
                first_we = (link == NOARC);
                first_wa = r_owner;
                first_wd = r_a;
                n_vok[r_owner] = 1'b1;
                n_state  = ST_AP_LINK;
            end
            ST_AP_LINK: begin
                next_we = (r_link != NOARC);
                next_wa = r_link[ARW-1:0];
                next_wd = r_a;
                if (!r_pass) begin
                    n_owner = r_hv;
                    n_hv    = r_owner;
                    n_a     = r_a | AW'(1);
                    n_resv  = '0;
                    n_pass  = 1'b1;
                    n_state = ST_AP_RD;
                end else begin
                    n_res.edge_id = 8'(r_cnt);
                    n_cnt   = r_cnt + CNW'(1);
                    n_state = ST_DONE;
                end
            end
            ST_RD0: begin
                head_ra = r_a[ARW-1:0];
                res_ra  = r_a[ARW-1:0];
                n_state = ST_RD1;
            end
            ST_RD1: begin
                n_h     = head_rd;
                n_r     = res_rd;
                head_ra = r_a[ARW-1:0] | ARW'(1);
                res_ra  = r_a[ARW-1:0] | ARW'(1);
                n_state = ST_RD2;
            end
            ST_RD2: begin
                n_res.edge_tail     = 6'(head_rd);
                n_res.edge_head     = 6'(r_h);
                n_res.edge_capacity = 32'(sum);
                n_res.edge_flow     = 32'(res_rd);
                n_state = ST_DONE;
            end
            ST_SW_INIT: begin
                n_seen      = '0;
                n_seen[r_s] = 1'b1;
                queue_we    = 1'b1;
                queue_wa    = '0;
                queue_wd    = r_s;
                level_we    = r_lev;
                level_wa    = r_s;
                level_wd    = '0;
                n_qh        = '0;
                n_qt        = QW'(1);
                n_state     = ST_SW_POP;
            end
            ST_SW_POP: begin
                if (r_qh == r_qt) begin
                    if (r_run) begin
                        n_state = ST_RUN_PHASE;
                    end else begin
                        n_res.on_source_side = r_seen[r_qv];
                        n_state = ST_DONE;
                    end
                end else begin
                    queue_ra = r_qh[VW-1:0];
                    n_qh     = r_qh + QW'(1);
                    n_state  = ST_SW_V;
                end
            end
            ST_SW_V: begin
                first_ra = queue_rd;
                level_ra = queue_rd;
                n_v      = queue_rd;
                n_state  = ST_SW_F;
            end
            ST_SW_F: begin
                n_a     = r_vok[r_v] ? first_rd : NOARC;
                n_lv    = level_rd;
                n_state = ST_SW_ARC;
            end
            ST_SW_ARC: begin
                if (r_a == NOARC) begin
                    n_state = ST_SW_POP;
                end else begin
                    head_ra = r_a[ARW-1:0];
                    res_ra  = r_a[ARW-1:0];
                    next_ra = r_a[ARW-1:0];
                    n_state = ST_SW_CHK;
                end
            end
            ST_SW_CHK: begin
                if (res_rd != '0 && !r_seen[head_rd]) begin
                    n_seen[head_rd] = 1'b1;
                    level_we = r_lev;
                    level_wa = head_rd;
                    level_wd = r_lv + VW'(1);
                    queue_we = 1'b1;
                    queue_wa = r_qt[VW-1:0];
                    queue_wd = head_rd;
                    n_qt     = r_qt + QW'(1);
                end
                n_a     = next_rd;
                n_state = ST_SW_ARC;
            end
            ST_RUN_LOOP: begin
                if (r_total >= r_lim) begin
                    n_res.total_flow = 32'(r_total);
                    n_state = ST_DONE;
                end else begin
                    n_lev   = 1'b1;
                    n_state = ST_SW_INIT;
                end
            end
            ST_RUN_PHASE: begin
                if (!r_seen[r_t]) begin
                    n_res.total_flow = 32'(r_total);
                    n_state = ST_DONE;
                end else begin
                    n_cok   = '0;
                    n_state = ST_P_START;
                end
            end
            ST_P_START: begin
                n_top   = '0;
                n_fv    = r_s;
                n_fup   = r_lim - r_total;
                n_fres  = '0;
                n_state = ST_P_FRAME;
            end
            ST_P_FRAME: begin
                if (r_fv == r_t) begin
                    n_ret   = r_fup;
                    n_state = ST_P_RET;
                end else begin
                    cur_ra   = r_fv;
                    first_ra = r_fv;
                    level_ra = r_fv;
                    n_state  = ST_P_CUR;
                end
            end
            ST_P_CUR: begin
                if (r_cok[r_fv]) begin
                    n_a = cur_rd;
                end else begin
                    n_a = r_vok[r_fv] ? first_rd : NOARC;
                end
                n_lv    = level_rd;
                n_state = ST_P_SCAN;
            end
            ST_P_SCAN: begin
                if (r_a == NOARC) begin
                    cur_we  = 1'b1;
                    cur_wa  = r_fv;
                    cur_wd  = NOARC;
                    n_cok[r_fv] = 1'b1;
                    n_ret   = r_fres;
                    n_state = ST_P_RET;
                end else begin
                    head_ra = r_a[ARW-1:0];
                    res_ra  = r_a[ARW-1:0];
                    next_ra = r_a[ARW-1:0];
                    n_state = ST_P_A;
                end
            end
            ST_P_A: begin
                n_h      = head_rd;
                n_r      = res_rd;
                n_nx     = next_rd;
                level_ra = head_rd;
                n_state  = ST_P_L;
            end
            ST_P_L: begin
                if (r_seen[r_h] && r_lv < level_rd && r_r != '0) begin
                    cur_we   = 1'b1;
                    cur_wa   = r_fv;
                    cur_wd   = r_a;
                    n_cok[r_fv] = 1'b1;
                    stack_we = 1'b1;
                    stack_wa = r_top;
                    stack_wd = {r_fv, r_fup, r_fres};
                    n_top    = r_top + VW'(1);
                    n_fv     = r_h;
                    n_fup    = (room < r_r) ? room : r_r;
                    n_fres   = '0;
                    n_state  = ST_P_FRAME;
                end else begin
                    n_a     = r_nx;
                    n_state = ST_P_SCAN;
                end
            end
            ST_P_RET: begin
                if (r_top == '0) begin
                    n_state = ST_P_END;
                end else begin
                    stack_ra = r_top - VW'(1);
                    n_top    = r_top - VW'(1);
                    n_state  = ST_P_POP1;
                end
            end
            ST_P_POP1: begin
                n_fv    = stack_rd[SW-1:2*CW];
                n_fup   = stack_rd[2*CW-1:CW];
                n_fres  = stack_rd[CW-1:0];
                cur_ra  = stack_rd[SW-1:2*CW];
                n_state = ST_P_POP2;
            end
            ST_P_POP2: begin
                n_a = cur_rd;
                if (r_ret != '0) begin
                    res_ra  = cur_rd[ARW-1:0];
                    n_state = ST_P_U1;
                end else begin
                    next_ra = cur_rd[ARW-1:0];
                    n_state = ST_P_ADV;
                end
            end
            ST_P_U1: begin
                res_we  = 1'b1;
                res_wa  = r_a[ARW-1:0];
                res_wd  = res_rd - r_ret;
                res_ra  = r_a[ARW-1:0] ^ ARW'(1);
                n_state = ST_P_U2;
            end
            ST_P_U2: begin
                res_we = 1'b1;
                res_wa = r_a[ARW-1:0] ^ ARW'(1);
                res_wd = res_rd + r_ret;
                n_fres = fsum;
                if (fsum == r_fup) begin
                    n_ret   = fsum;
                    n_state = ST_P_RET;
                end else begin
                    next_ra = r_a[ARW-1:0];
                    n_state = ST_P_ADV;
                end
            end
            ST_P_ADV: begin
                cur_we  = 1'b1;
                cur_wa  = r_fv;
                cur_wd  = next_rd;
                n_state = ST_P_FRAME;
            end
            ST_P_END: begin
                if (r_ret == '0) begin
                    n_state = ST_RUN_LOOP;
                end else begin
                    n_total = tsum;
                    if (tsum == r_lim) begin
                        n_res.total_flow = 32'(tsum);
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_P_START;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qh <= r_qt) else $error("bfs queue head passed tail");
    a_edge_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNW'(MAX_EDGES)) else $error("edge count above table size");
    a_flow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= r_lim) else $error("total flow above limit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_cmd_valid && i_cmd.mode == MODE_CLEAR)
        |=> (r_cnt == '0 && r_vok == '0)) else $error("clear left graph state");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_dinic_max_flow_engine.sv
// testbench for the dinic max-flow engine: stream stimulus, self-contained predictor, checks
`timescale 1ns / 1ps

module tb_dinic_max_flow_engine;
    import dmf_pkg::*;

    localparam int NV = 64;
    localparam int NE = 256;
    localparam int NARC = 2 * NE;
    localparam logic [9:0] NO_ARC = 10'd512;
    localparam logic [2:0] MODE_BAD_LO = 3'd5;
    localparam logic [2:0] MODE_BAD_HI = 3'd7;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [55:0]  i_s_tdata;
    logic [2:0]   i_s_tuser;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [119:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    dinic_max_flow_engine i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // graph model
    logic [5:0]      arc_to[NARC];
    longint unsigned arc_res[NARC];
    logic [9:0]      arc_nx[NARC];
    logic [9:0]      v_first[NV];
    logic [9:0]      v_last[NV];
    int              n_edges;
    int              lvl[NV];
    logic [9:0]      cur[NV];
    bit              reach[NV];
    logic [5:0]      stk_v[NV];
    longint unsigned stk_up[NV];
    longint unsigned stk_got[NV];
    logic [5:0]      src_v;
    logic [5:0]      snk_v;
    longint unsigned lim;

    t_cmd cmd_q[$];
    t_res flow_exp_q[$];
    int   errors;
    int   n_shown;
    int   n_taken;
    int   burst_left;
    int   gap_left;
    int   calm_left;

    function automatic void graph_clear();
        for (int i = 0; i < NV; i++) begin
            v_first[i] = NO_ARC;
            v_last[i] = NO_ARC;
            lvl[i] = -1;
            reach[i] = 0;
        end
        n_edges = 0;
    endfunction

    function automatic void link_arc(logic [5:0] owner, logic [9:0] a, logic [5:0] head,
                                     longint unsigned res);
        arc_to[a] = head;
        arc_res[a] = res;
        arc_nx[a] = NO_ARC;
        if (v_last[owner] == NO_ARC) v_first[owner] = a;
        else arc_nx[v_last[owner]] = a;
        v_last[owner] = a;
    endfunction

    function automatic void bfs_sweep(logic [5:0] s, bit leveling);
        logic [5:0] q[NV];
        int qh;
        int qt;
        logic [5:0] v;
        logic [5:0] h;
        logic [9:0] a;
        bit fresh;
        qh = 0;
        qt = 0;
        for (int i = 0; i < NV; i++) begin
            if (leveling) lvl[i] = -1;
            else reach[i] = 0;
        end
        if (leveling) lvl[s] = 0;
        else reach[s] = 1;
        q[qt] = s;
        qt = qt + 1;
        while (qh < qt) begin
            v = q[qh];
            qh = qh + 1;
            a = v_first[v];
            while (a != NO_ARC) begin
                h = arc_to[a];
                if (arc_res[a] > 0) begin
                    fresh = leveling ? (lvl[h] < 0) : !reach[h];
                    if (fresh && qt < NV) begin
                        if (leveling) lvl[h] = lvl[v] + 1;
                        else reach[h] = 1;
                        q[qt] = h;
                        qt = qt + 1;
                    end
                end
                a = arc_nx[a];
            end
        end
    endfunction

    function automatic longint unsigned push_path(logic [5:0] s, logic [5:0] t,
                                                  longint unsigned up);
        int top;
        logic [5:0] v;
        logic [9:0] a;
        longint unsigned ret;
        longint unsigned room;
        bit done;
        top = 0;
        stk_v[0] = s;
        stk_up[0] = up;
        stk_got[0] = 0;
        forever begin
            v = stk_v[top];
            ret = 0;
            done = 0;
            if (v == t) begin
                ret = stk_up[top];
                done = 1;
            end else begin
                a = cur[v];
                while (a != NO_ARC) begin
                    if (lvl[v] < lvl[arc_to[a]] && arc_res[a] > 0 && top + 1 < NV) break;
                    a = arc_nx[a];
                    cur[v] = a;
                end
                if (a == NO_ARC) begin
                    ret = stk_got[top];
                    done = 1;
                end else begin
                    room = stk_up[top] - stk_got[top];
                    stk_v[top + 1] = arc_to[a];
                    stk_up[top + 1] = (room < arc_res[a]) ? room : arc_res[a];
                    stk_got[top + 1] = 0;
                    top++;
                    continue;
                end
            end
            while (done) begin
                if (top == 0) return ret;
                top--;
                a = cur[stk_v[top]];
                if (ret > 0) begin
                    arc_res[a] -= ret;
                    arc_res[a ^ 10'd1] += ret;
                    stk_got[top] += ret;
                    if (stk_got[top] == stk_up[top]) begin
                        ret = stk_got[top];
                        continue;
                    end
                end
                cur[stk_v[top]] = arc_nx[a];
                done = 0;
            end
        end
    endfunction

    function automatic longint unsigned max_flow();
        longint unsigned total;
        longint unsigned f;
        total = 0;
        while (total < lim) begin
            bfs_sweep(src_v, 1);
            if (lvl[snk_v] < 0) return total;
            for (int i = 0; i < NV; i++) cur[i] = v_first[i];
            f = push_path(src_v, snk_v, lim - total);
            while (f > 0) begin
                total += f;
                if (total == lim) return total;
                f = push_path(src_v, snk_v, lim - total);
            end
        end
        return total;
    endfunction

    function automatic t_res predict_result(t_cmd c);
        t_res r;
        logic [9:0] a;
        r = '0;
        case (c.mode)
            MODE_CLEAR: graph_clear();
            MODE_ADD: begin
                if (n_edges >= NE) begin
                    r.status = STAT_FULL;
                end else begin
                    a = 10'(2 * n_edges);
                    link_arc(c.from_vertex, a, c.to_vertex, c.capacity);
                    link_arc(c.to_vertex, a + 10'd1, c.from_vertex, 0);
                    r.edge_id = 8'(n_edges);
                    n_edges++;
                end
            end
            MODE_RUN: r.total_flow = 32'(max_flow());
            MODE_READ: begin
                if (int'(c.edge_index) >= n_edges) begin
                    r.status = STAT_MISSING;
                end else begin
                    a = {1'b0, c.edge_index, 1'b0};
                    r.edge_tail = arc_to[a + 10'd1];
                    r.edge_head = arc_to[a];
                    r.edge_capacity = 32'(arc_res[a] + arc_res[a + 10'd1]);
                    r.edge_flow = 32'(arc_res[a + 10'd1]);
                end
            end
            MODE_CUT: begin
                bfs_sweep(src_v, 0);
                r.on_source_side = reach[c.from_vertex];
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, longint unsigned e, longint unsigned g);
        if (e != g) begin
            $error("%s mismatch: expected %0d, got %0d", name, e, g);
            errors++;
        end
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("simulation failed");
        $finish;
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 0;
        end else if (!i_s_tvalid || n_taken == n_shown) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_s_tvalid <= 0;
            end else if (cmd_q.size() > 0) begin
                i_s_tvalid <= 1;
                i_s_tuser <= cmd_q[0].mode;
                i_s_tdata <= {4'd0, cmd_q[0].edge_index, cmd_q[0].capacity,
                              cmd_q[0].to_vertex, cmd_q[0].from_vertex};
                n_shown <= n_shown + 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_s_tvalid <= 0;
            end
        end
    end

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (calm_left > 0) begin
            calm_left <= calm_left - 1;
            i_m_tready <= 1;
        end else if ($urandom_range(0, 40) == 0) begin
            calm_left <= $urandom_range(10, 60);
            i_m_tready <= 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // input acceptance and result checking
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            flow_exp_q.insert(flow_exp_q.size(), predict_result(cmd_q.pop_front()));
            n_taken <= n_taken + 1;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = o_m_tuser;
            got.edge_id = o_m_tdata[7:0];
            got.total_flow = o_m_tdata[39:8];
            got.edge_tail = o_m_tdata[45:40];
            got.edge_head = o_m_tdata[51:46];
            got.edge_capacity = o_m_tdata[83:52];
            got.edge_flow = o_m_tdata[115:84];
            got.on_source_side = o_m_tdata[116];
            if (flow_exp_q.size() == 0) begin
                $error("result transfer with no expected result");
                errors++;
            end else begin
                want = flow_exp_q.pop_front();
                check_field("status", want.status, got.status);
                check_field("edge_id", want.edge_id, got.edge_id);
                check_field("total_flow", want.total_flow, got.total_flow);
                check_field("edge_tail", want.edge_tail, got.edge_tail);
                check_field("edge_head", want.edge_head, got.edge_head);
                check_field("edge_capacity", want.edge_capacity, got.edge_capacity);
                check_field("edge_flow", want.edge_flow, got.edge_flow);
                check_field("on_source_side", want.on_source_side, got.on_source_side);
            end
        end
    end

    task automatic put(logic [2:0] mode, logic [5:0] fv, logic [5:0] tv, logic [31:0] cap,
                       logic [7:0] idx);
        t_cmd c;
        c.mode = mode;
        c.from_vertex = fv;
        c.to_vertex = tv;
        c.capacity = cap;
        c.edge_index = idx;
        cmd_q.insert(cmd_q.size(), c);
    endtask

    task automatic put_rand(logic [2:0] mode);
        put(mode, 6'($urandom), 6'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic put_edge(logic [5:0] span, bit wide_cap);
        put(MODE_ADD, 6'($urandom_range(0, span)), 6'($urandom_range(0, span)),
            wide_cap ? $urandom : $urandom_range(0, 20), 8'($urandom));
    endtask

    task automatic drain();
        while (cmd_q.size() > 0 || flow_exp_q.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_SOURCE: src_v = val[5:0];
            CFG_SINK:   snk_v = val[5:0];
            CFG_LIMIT:  lim = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic random_phase(logic [5:0] span);
        int n;
        cfg_write(CFG_SOURCE, {26'($urandom), 6'($urandom_range(0, span))});
        cfg_write(CFG_SINK, {26'($urandom), 6'($urandom_range(0, span))});
        case ($urandom_range(0, 2))
            0: cfg_write(CFG_LIMIT, 32'hFFFF_FFFF);
            1: cfg_write(CFG_LIMIT, $urandom_range(1, 30));
            default: cfg_write(CFG_LIMIT, $urandom);
        endcase
        put_rand(MODE_CLEAR);
        n = $urandom_range(8, 16);
        repeat (n) put_edge(span, $urandom_range(0, 3) == 0);
        repeat ($urandom_range(8, 14)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: put_rand(MODE_RUN);
                3, 4:    put(MODE_READ, 6'($urandom), 6'($urandom), $urandom,
                             8'($urandom_range(0, n + 1)));
                5, 6:    put(MODE_CUT, 6'($urandom_range(0, span)), 6'($urandom),
                             $urandom, 8'($urandom));
                7:       put_edge(span, 1);
                8:       put_rand(3'($urandom_range(MODE_BAD_LO, MODE_BAD_HI)));
                default: put_rand(MODE_CUT);
            endcase
        end
        drain();
    endtask

    initial begin
        i_rst_n = 0;
        i_s_tvalid = 0;
        i_s_tdata = '0;
        i_s_tuser = '0;
        i_m_tready = 0;
        i_cfg_valid = 0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        errors = 0;
        n_shown = 0;
        n_taken = 0;
        burst_left = 1;
        gap_left = 0;
        calm_left = 0;
        src_v = 0;
        snk_v = 1;
        lim = 32'hFFFF_FFFF;
        graph_clear();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;

        // empty graph, small network with reset settings, self loop, unknown modes
        put(MODE_READ, 0, 0, 0, 0);
        put(MODE_CUT, 0, 0, 0, 0);
        put(MODE_CUT, 63, 0, 0, 0);
        put(MODE_BAD_LO, 6'h3F, 6'h3F, 32'hFFFF_FFFF, 8'hFF);
        put(MODE_BAD_HI, 0, 0, 0, 0);
        put(MODE_ADD, 0, 2, 10, 0);
        put(MODE_ADD, 2, 1, 32'hFFFF_FFFF, 0);
        put(MODE_ADD, 0, 1, 5, 0);
        put(MODE_ADD, 3, 3, 7, 0);
        put(MODE_ADD, 63, 62, 0, 0);
        put(MODE_RUN, 0, 0, 0, 0);
        put(MODE_READ, 0, 0, 0, 0);
        put(MODE_READ, 0, 0, 0, 1);
        put(MODE_READ, 0, 0, 0, 3);
        put(MODE_READ, 0, 0, 0, 8'hFF);
        put(MODE_CUT, 2, 0, 0, 0);
        put(MODE_CUT, 1, 0, 0, 0);
        put(MODE_RUN, 0, 0, 0, 0);
        put(MODE_CLEAR, 0, 0, 0, 0);
        put(MODE_READ, 0, 0, 0, 0);
        drain();

        // flow limit caps the run, then source equals sink, then zero limit
        cfg_write(CFG_SOURCE, 63);
        cfg_write(CFG_SINK, 62);
        cfg_write(CFG_LIMIT, 7);
        put(MODE_ADD, 63, 62, 100, 0);
        put(MODE_ADD, 63, 5, 32'hFFFF_FFFF, 0);
        put(MODE_ADD, 5, 62, 3, 0);
        put(MODE_RUN, 0, 0, 0, 0);
        put(MODE_RUN, 0, 0, 0, 0);
        put(MODE_READ, 0, 0, 0, 0);
        put(MODE_CUT, 5, 0, 0, 0);
        drain();
        cfg_write(CFG_SINK, 63);
        put(MODE_RUN, 0, 0, 0, 0);
        drain();
        cfg_write(CFG_SINK, 62);
        cfg_write(CFG_LIMIT, 0);
        put(MODE_RUN, 0, 0, 0, 0);
        put(MODE_READ, 0, 0, 0, 2);
        drain();

        repeat (4) random_phase(7);
        random_phase(63);

        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/dmf_pkg.sv
rtl/dmf_ram.sv
rtl/dmf_core.sv
rtl/dinic_max_flow_engine.sv
tb/sv/tb_dinic_max_flow_engine.sv
